// ----- design/tjc_pkg.sv -----
// tjc_pkg: shared widths, codes and small helpers for the Tremaux junction chooser.
// No dependencies; imported by every module of the block.
`default_nettype none

package tjc_pkg;

  localparam int HEAD_W       = 9;
  localparam int POS_W        = 14;
  localparam int CELL_W       = 8;     // stored position, 50 mm units
  localparam int MARKS_W      = 8;     // 2 bits per direction
  localparam int ENTRY_W      = 24;
  localparam int DIFF_W       = POS_W + 1;
  localparam int SQ_W         = 28;
  localparam int D2_W         = SQ_W + 1;
  localparam int TURN_W       = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int DEF_TABLE_DEPTH = 64;

  localparam logic [D2_W-1:0] MATCH_D2 = D2_W'(67600);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HAND_RULE     = CFG_IDX_W'(1);

  // turn codes; the low two bits are the direction offset mod 4
  localparam logic [TURN_W-1:0] TURN_LEFT     = 3'b001;
  localparam logic [TURN_W-1:0] TURN_STRAIGHT = 3'b000;
  localparam logic [TURN_W-1:0] TURN_RIGHT    = 3'b111;
  localparam logic [TURN_W-1:0] TURN_AROUND   = 3'b010;

  typedef struct packed {
    logic            valid;
    logic            busy;
    logic [D2_W-1:0] d2;
  } dist_res_t;

  typedef struct packed {
    logic [TURN_W-1:0]  turn;
    logic [MARKS_W-1:0] marks;
  } decide_t;

  // cell coordinate to mm: v * 50 = v*32 + v*16 + v*2
  function automatic logic signed [POS_W-1:0] cell_to_mm(input logic signed [CELL_W-1:0] v);
    logic signed [POS_W-1:0] w;
    w = POS_W'(v);
    return (w <<< 5) + (w <<< 4) + (w <<< 1);
  endfunction

  function automatic logic [TURN_W-1:0] hand_turn(input logic hand, input logic l,
                                                  input logic f, input logic r);
    logic [TURN_W-1:0] t;
    t = TURN_AROUND;
    if (!hand) begin
      if (l) t = TURN_LEFT;
      else if (f) t = TURN_STRAIGHT;
      else if (r) t = TURN_RIGHT;
    end else begin
      if (r) t = TURN_RIGHT;
      else if (f) t = TURN_STRAIGHT;
      else if (l) t = TURN_LEFT;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- design/tjc_quant.sv -----
// tjc_quant: mm to 50 mm cells, rounded half away from zero, saturated to 8 bits.
// Divide by 50 through a reciprocal multiply; one register stage. Uses tjc_pkg.
`default_nettype none

module tjc_quant import tjc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [POS_W-1:0]  pos_mm,
  output logic signed [CELL_W-1:0]      units
);

  localparam int RECIP_SH = 19;
  localparam int PROD_W   = 2 * POS_W;
  localparam logic [POS_W-1:0] RECIP    = POS_W'(((1 << RECIP_SH) + 49) / 50);
  localparam logic [POS_W-1:0] HALF_UNIT = POS_W'(25);

  logic [POS_W-1:0]  mag;
  logic [POS_W-1:0]  num;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  logic [8:0]        quo;

  assign mag = pos_mm[POS_W-1] ? POS_W'(-pos_mm) : POS_W'(pos_mm);
  assign num = mag + HALF_UNIT;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(num) * PROD_W'(RECIP);
    neg_r  <= pos_mm[POS_W-1];
  end

  assign quo = prod_r[RECIP_SH +: 9];

  always_comb begin
    if (neg_r) begin
      units = (quo > 9'd128) ? -8'sd128 : CELL_W'(9'd0 - quo);
    end else begin
      units = (quo > 9'd127) ? 8'sd127 : CELL_W'(quo);
    end
  end

endmodule

`default_nettype wire

// ----- design/tjc_dist_unit.sv -----
// tjc_dist_unit: shared squared-distance unit, one table entry per cycle, two stages.
// Difference stage, then squaring stage; the sum is formed at the output. Uses tjc_pkg.
`default_nettype none

module tjc_dist_unit import tjc_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    ent_valid,
  input  wire logic [IDX_W-1:0]        ent_idx,
  input  wire logic [2*CELL_W-1:0]     ent_pos,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  output dist_res_t                    res,
  output logic [IDX_W-1:0]             res_idx
);

  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic                     v1_r, v2_r;
  logic [IDX_W-1:0]         idx1_r, idx2_r;
  logic signed [POS_W-1:0]  ex, ey;
  logic signed [2*DIFF_W-1:0] px, py;

  assign ex = cell_to_mm(ent_pos[CELL_W-1:0]);
  assign ey = cell_to_mm(ent_pos[2*CELL_W-1:CELL_W]);
  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ent_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= DIFF_W'(ex) - DIFF_W'(pos_x);
    dy_r   <= DIFF_W'(ey) - DIFF_W'(pos_y);
    idx1_r <= ent_idx;
    sqx_r  <= px[SQ_W-1:0];
    sqy_r  <= py[SQ_W-1:0];
    idx2_r <= idx1_r;
  end

  assign res.valid = v2_r;
  assign res.busy  = v1_r | v2_r;
  assign res.d2    = D2_W'(sqx_r) + D2_W'(sqy_r);
  assign res_idx   = idx2_r;

endmodule

`default_nettype wire

// ----- design/tjc_mark_logic.sv -----
// tjc_mark_logic: use-mark update and passage choice for one junction entry.
// Marks the arrival passage, picks the least-marked candidate, marks it. Uses tjc_pkg.
`default_nettype none

module tjc_mark_logic import tjc_pkg::*; (
  input  wire logic [MARKS_W-1:0] marks_in,
  input  wire logic [1:0]         here,
  input  wire logic               first_done,
  input  wire logic               hand,
  input  wire logic               open_l,
  input  wire logic               open_f,
  input  wire logic               open_r,
  output decide_t                 dec
);

  function automatic logic [1:0] sat_inc(input logic [1:0] m);
    return (m < 2'd2) ? m + 2'd1 : 2'd2;
  endfunction

  logic [1:0]         back, d, m, bm, chosen;
  logic [MARKS_W-1:0] marks1, marks2;
  logic [TURN_W-1:0]  cand_turn [4];
  logic [3:0]         cand_open;
  logic [TURN_W-1:0]  turn;

  always_comb begin
    back   = here + 2'd2;
    marks1 = marks_in;
    // first decision: arrival marked three times, which saturates
    marks1[{back, 1'b0} +: 2] = first_done ? sat_inc(marks_in[{back, 1'b0} +: 2]) : 2'd2;

    if (!hand) begin
      cand_turn[0] = TURN_LEFT;  cand_open[0] = open_l;
      cand_turn[2] = TURN_RIGHT; cand_open[2] = open_r;
    end else begin
      cand_turn[0] = TURN_RIGHT; cand_open[0] = open_r;
      cand_turn[2] = TURN_LEFT;  cand_open[2] = open_l;
    end
    cand_turn[1] = TURN_STRAIGHT; cand_open[1] = open_f;
    cand_turn[3] = TURN_AROUND;   cand_open[3] = 1'b1;

    turn = TURN_AROUND;
    bm   = 2'd3;
    for (int k = 0; k < 4; k++) begin
      d = here + cand_turn[k][1:0];
      m = marks1[{d, 1'b0} +: 2];
      if (cand_open[k] && (m < bm)) begin
        bm   = m;
        turn = cand_turn[k];
      end
    end

    chosen = here + turn[1:0];
    marks2 = marks1;
    marks2[{chosen, 1'b0} +: 2] = sat_inc(marks1[{chosen, 1'b0} +: 2]);

    dec.turn  = turn;
    dec.marks = marks2;
  end

endmodule

`default_nettype wire

// ----- design/tremaux_junction_chooser.sv -----
// tremaux_junction_chooser: top level; sequencer, junction table memory, output register.
// Instantiates tjc_dist_unit, tjc_quant, tjc_mark_logic; uses tjc_pkg.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | heading, x, y, open left/front/right
//  out_    | output    | out_valid / out_ready| turn, snapped flag, snapped x/y, full flag
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (bit 0)
//
// Tremaux mode: the linear table scan through the shared distance unit, one entry a cycle,
// dominates the time from one accept to the next. Wall-follow mode goes straight from
// the idle state to the done state.
// in_ready is high only while the sequencer is idle.
// A finished result waits in the out_ register; the sequencer holds its last state
// while that register is still occupied. Reset empties the table by clearing the fill
// count; the table memory itself is never cleared. cfg_ready is always high.
`default_nettype none

module tremaux_junction_chooser import tjc_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [HEAD_W-1:0]  in_heading_deg,
  input  wire logic signed [POS_W-1:0]   in_pos_x_mm,
  input  wire logic signed [POS_W-1:0]   in_pos_y_mm,
  input  wire logic                      in_open_left,
  input  wire logic                      in_open_front,
  input  wire logic                      in_open_right,

  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [TURN_W-1:0]       out_turn_quarters,
  output logic                           out_position_snapped,
  output logic signed [POS_W-1:0]        out_snapped_x_mm,
  output logic signed [POS_W-1:0]        out_snapped_y_mm,
  output logic                           out_memory_full,

  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_DECIDE  = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic             mode_r, hand_r;
  logic [CNT_W-1:0] count_r, scan_idx_r;
  logic             first_r, found_r, new_ok;
  logic             v1_r;
  logic [IDX_W-1:0] idx1_r, best_idx_r, tgt_idx_r, rd_addr;
  logic [D2_W-1:0]  best_d2_r;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] base;

  logic signed [POS_W-1:0] x_r, y_r;
  logic [1:0]              here_r, here;
  logic                    ol_r, of_r, or_r;

  logic [TURN_W-1:0]       res_turn_r;
  logic                    res_snap_r, res_full_r;
  logic signed [POS_W-1:0] res_x_r, res_y_r;
  logic                    out_valid_r;

  logic                    accept, issue, out_load;
  logic signed [CELL_W-1:0] qx, qy;
  logic signed [HEAD_W:0]  hw, t45;
  dist_res_t               dres;
  logic [IDX_W-1:0]        dres_idx;
  decide_t                 dec;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign issue     = (state_r == ST_SCAN) && (scan_idx_r < count_r);
  assign new_ok    = (count_r < DEPTH_C);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // heading to direction index: 0 +x, 1 +y, 2 -x, 3 -y
  always_comb begin
    hw = (HEAD_W+1)'(in_heading_deg);
    if (hw > 10'sd180) hw = hw - 10'sd360;
    else if (hw < -10'sd180) hw = hw + 10'sd360;
    t45 = hw + 10'sd45;
    if (t45 < -10'sd90)      here = 2'd2;
    else if (t45 < 10'sd0)   here = 2'd3;
    else if (t45 < 10'sd90)  here = 2'd0;
    else if (t45 < 10'sd180) here = 2'd1;
    else                     here = 2'd2;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept) state_nxt = mode_r ? ST_SCAN : ST_DONE;
      ST_SCAN:    if (!issue) state_nxt = ST_DRAIN;
      ST_DRAIN:   if (!v1_r && !dres.busy) state_nxt = ST_RESOLVE;
      ST_RESOLVE: state_nxt = (found_r || new_ok) ? ST_DECIDE : ST_DONE;
      ST_DECIDE:  state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b1;
      hand_r      <= 1'b0;
      count_r     <= '0;
      first_r     <= 1'b0;
      found_r     <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_STRATEGY_MODE: mode_r <= cfg_data[0];
          CFG_HAND_RULE:     hand_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      if (issue) scan_idx_r <= scan_idx_r + 1'b1;
      if (dres.valid && (dres.d2 < best_d2_r)) found_r <= 1'b1;
      if (state_r == ST_DECIDE) begin
        first_r <= 1'b1;
        if (!found_r) count_r <= count_r + 1'b1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    idx1_r <= scan_idx_r[IDX_W-1:0];
    if (accept) begin
      x_r        <= in_pos_x_mm;
      y_r        <= in_pos_y_mm;
      here_r     <= here;
      ol_r       <= in_open_left;
      of_r       <= in_open_front;
      or_r       <= in_open_right;
      best_d2_r  <= MATCH_D2;
      res_turn_r <= hand_turn(hand_r, in_open_left, in_open_front, in_open_right);
      res_snap_r <= 1'b0;
      res_full_r <= 1'b0;
      res_x_r    <= in_pos_x_mm;
      res_y_r    <= in_pos_y_mm;
    end
    // strict compare keeps the earliest entry on ties
    if (dres.valid && (dres.d2 < best_d2_r)) begin
      best_d2_r  <= dres.d2;
      best_idx_r <= dres_idx;
    end
    if (state_r == ST_RESOLVE) begin
      tgt_idx_r <= found_r ? best_idx_r : count_r[IDX_W-1:0];
      if (!found_r && !new_ok) res_full_r <= 1'b1;
    end
    if (state_r == ST_DECIDE) begin
      res_turn_r <= dec.turn;
      res_snap_r <= found_r;
      if (found_r) begin
        res_x_r <= cell_to_mm(base[CELL_W-1:0]);
        res_y_r <= cell_to_mm(base[2*CELL_W-1:CELL_W]);
      end
    end
    if (out_load) begin
      out_turn_quarters    <= res_turn_r;
      out_position_snapped <= res_snap_r;
      out_snapped_x_mm     <= res_x_r;
      out_snapped_y_mm     <= res_y_r;
      out_memory_full      <= res_full_r;
    end
  end

  // junction table: one write port, one registered read port
  assign rd_addr = (state_r == ST_SCAN) ? scan_idx_r[IDX_W-1:0] : best_idx_r;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (state_r == ST_DECIDE) mem[tgt_idx_r] <= {dec.marks, base[2*CELL_W-1:0]};
  end

  assign base = found_r ? rd_data_r : {MARKS_W'(0), qy, qx};
  assign out_valid = out_valid_r;

  tjc_dist_unit #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (v1_r),
    .ent_idx   (idx1_r),
    .ent_pos   (rd_data_r[2*CELL_W-1:0]),
    .pos_x     (x_r),
    .pos_y     (y_r),
    .res       (dres),
    .res_idx   (dres_idx)
  );

  tjc_quant u_quant_x (
    .clk    (clk),
    .pos_mm (x_r),
    .units  (qx)
  );

  tjc_quant u_quant_y (
    .clk    (clk),
    .pos_mm (y_r),
    .units  (qy)
  );

  tjc_mark_logic u_marks (
    .marks_in   (base[ENTRY_W-1:2*CELL_W]),
    .here       (here_r),
    .first_done (first_r),
    .hand       (hand_r),
    .open_l     (ol_r),
    .open_f     (of_r),
    .open_r     (or_r),
    .dec        (dec)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tremaux_junction_chooser_tb.sv -----
// Self-checking testbench for tremaux_junction_chooser: directed and random junction decisions,
// checked beat by beat against an in-bench predictor of the junction table and use marks.
// Depends on tjc_pkg and the tremaux_junction_chooser RTL only.
module tremaux_junction_chooser_tb;
  import tjc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int LIMIT_CYCLES = 600_000;
  localparam int JUNCTIONS    = DEF_TABLE_DEPTH;
  localparam int NSITES       = 24;
  localparam int MATCH_MM2    = 67600;
  localparam int UNIT_MM      = 50;
  localparam int SETTLE_CYCLES = 80;   // outlasts a full-table scan

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(3);
  localparam logic WALL_FOLLOW = 1'b0;
  localparam logic TREMAUX     = 1'b1;
  localparam logic LEFT_HAND   = 1'b0;
  localparam logic RIGHT_HAND  = 1'b1;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic                     left;
    logic                     front;
    logic                     right;
  } junction_t;

  typedef struct packed {
    logic signed [TURN_W-1:0] turn;
    logic                     snapped;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic                     full;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [HEAD_W-1:0] in_heading_deg = '0;
  logic signed [POS_W-1:0]  in_pos_x_mm = '0;
  logic signed [POS_W-1:0]  in_pos_y_mm = '0;
  logic                     in_open_left = 1'b0;
  logic                     in_open_front = 1'b0;
  logic                     in_open_right = 1'b0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TURN_W-1:0] out_turn_quarters;
  logic                     out_position_snapped;
  logic signed [POS_W-1:0]  out_snapped_x_mm;
  logic signed [POS_W-1:0]  out_snapped_y_mm;
  logic                     out_memory_full;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  tremaux_junction_chooser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_heading_deg       (in_heading_deg),
    .in_pos_x_mm          (in_pos_x_mm),
    .in_pos_y_mm          (in_pos_y_mm),
    .in_open_left         (in_open_left),
    .in_open_front        (in_open_front),
    .in_open_right        (in_open_right),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_turn_quarters    (out_turn_quarters),
    .out_position_snapped (out_position_snapped),
    .out_snapped_x_mm     (out_snapped_x_mm),
    .out_snapped_y_mm     (out_snapped_y_mm),
    .out_memory_full      (out_memory_full),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // predictor state
  logic                  tremaux_on = TREMAUX;
  logic                  right_hand = LEFT_HAND;
  int                    filled = 0;
  logic                  first_done = 1'b0;
  logic signed [7:0]     cell_x [JUNCTIONS];
  logic signed [7:0]     cell_y [JUNCTIONS];
  logic [1:0]            marks [JUNCTIONS][4];

  decision_t decisions_due[$];
  decision_t want;
  junction_t taken;

  int mismatches = 0;
  int n_items = 0;
  int n_beats = 0;
  int n_snapped = 0;
  int n_new = 0;
  int n_full = 0;
  int n_wall = 0;

  // stimulus control
  int   pend_gap = 0;
  int   hold_cycles = 0;
  logic burst = 1'b0;
  logic site_seen [NSITES];

  function automatic logic [TURN_W-1:0] hand_choice(logic l, logic f, logic r);
    logic [TURN_W-1:0] pick;
    pick = TURN_AROUND;
    if (right_hand) begin
      if (r) pick = TURN_RIGHT;
      else if (f) pick = TURN_STRAIGHT;
      else if (l) pick = TURN_LEFT;
    end else begin
      if (l) pick = TURN_LEFT;
      else if (f) pick = TURN_STRAIGHT;
      else if (r) pick = TURN_RIGHT;
    end
    return pick;
  endfunction

  // mm to 50 mm cells, halves away from zero, clamped to a signed byte
  function automatic logic signed [7:0] to_cells(logic signed [POS_W-1:0] v);
    int a;
    int q;
    a = v;
    if (a < 0) a = -a;
    q = (a + UNIT_MM / 2) / UNIT_MM;
    if (v < 0) q = -q;
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return q[7:0];
  endfunction

  function automatic void bump(int e, int d);
    if (marks[e][d] < 2'd2) marks[e][d] = marks[e][d] + 2'd1;
  endfunction

  function automatic decision_t decide_junction(junction_t j);
    decision_t res;
    int h;
    int here;
    int back;
    int best;
    int k;
    int low;
    int mm;
    longint dx;
    longint dy;
    longint d2;
    longint best_d2;
    logic [TURN_W-1:0] order [4];
    logic opn [4];
    res.turn    = hand_choice(j.left, j.front, j.right);
    res.snapped = 1'b0;
    res.x       = j.x;
    res.y       = j.y;
    res.full    = 1'b0;
    if (!tremaux_on) begin
      n_wall++;
      return res;
    end
    h = j.heading;
    while (h > 180) h -= 360;
    while (h < -180) h += 360;
    here = ((h + 405) / 90) % 4;
    back = (here + 2) % 4;
    best = -1;
    best_d2 = MATCH_MM2;
    for (k = 0; k < filled; k++) begin
      dx = longint'(cell_x[k]) * UNIT_MM - longint'(j.x);
      dy = longint'(cell_y[k]) * UNIT_MM - longint'(j.y);
      d2 = dx * dx + dy * dy;
      if (d2 < best_d2) begin
        best_d2 = d2;
        best = k;
      end
    end
    if (best >= 0) begin
      res.snapped = 1'b1;
      mm = cell_x[best];
      mm = mm * UNIT_MM;
      res.x = mm[POS_W-1:0];
      mm = cell_y[best];
      mm = mm * UNIT_MM;
      res.y = mm[POS_W-1:0];
      n_snapped++;
    end else if (filled < JUNCTIONS) begin
      best = filled;
      cell_x[best] = to_cells(j.x);
      cell_y[best] = to_cells(j.y);
      for (k = 0; k < 4; k++) marks[best][k] = 2'd0;
      filled++;
      n_new++;
    end
    if (best < 0) begin
      res.full = 1'b1;
      n_full++;
      return res;
    end
    bump(best, back);
    if (!first_done) begin
      // first decision of the run: the start passage counts as fully used
      first_done = 1'b1;
      bump(best, back);
      bump(best, back);
    end
    if (right_hand) begin
      order = '{TURN_RIGHT, TURN_STRAIGHT, TURN_LEFT, TURN_AROUND};
      opn   = '{j.right, j.front, j.left, 1'b1};
    end else begin
      order = '{TURN_LEFT, TURN_STRAIGHT, TURN_RIGHT, TURN_AROUND};
      opn   = '{j.left, j.front, j.right, 1'b1};
    end
    low = 99;
    res.turn = TURN_AROUND;
    for (k = 0; k < 4; k++) begin
      if (opn[k] && int'(marks[best][(here + order[k][1:0]) % 4]) < low) begin
        low = marks[best][(here + order[k][1:0]) % 4];
        res.turn = order[k];
      end
    end
    bump(best, (here + res.turn[1:0]) % 4);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STRATEGY_MODE) tremaux_on = cfg_data[0];
        else if (cfg_index == CFG_HAND_RULE) right_hand = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        taken.heading = in_heading_deg;
        taken.x       = in_pos_x_mm;
        taken.y       = in_pos_y_mm;
        taken.left    = in_open_left;
        taken.front   = in_open_front;
        taken.right   = in_open_right;
        decisions_due.push_back(decide_junction(taken));
        n_items++;
      end
    end
  end

  task automatic compare(string what, logic signed [POS_W-1:0] exp_v,
                         logic signed [POS_W-1:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_beats++;
      if (decisions_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing outstanding, expected none, actual turn %0d",
                 $time, out_turn_quarters);
      end else begin
        want = decisions_due.pop_front();
        compare("turn_quarters", want.turn, out_turn_quarters);
        compare("position_snapped", want.snapped, out_position_snapped);
        compare("snapped_x_mm", want.x, out_snapped_x_mm);
        compare("snapped_y_mm", want.y, out_snapped_y_mm);
        compare("memory_full", want.full, out_memory_full);
      end
    end
  end

  // result side: random stall per beat, plus any long hold requested by a test
  initial begin : result_sink
    int wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      wait_n = burst ? 0 : $urandom_range(0, 3);
      wait_n += hold_cycles;
      hold_cycles = 0;
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // valid stays up across back-to-back beats; it drops only when the next beat has a gap
  task automatic offer(junction_t j);
    repeat (pend_gap) @(posedge clk);
    in_valid       <= 1'b1;
    in_heading_deg <= j.heading;
    in_pos_x_mm    <= j.x;
    in_pos_y_mm    <= j.y;
    in_open_left   <= j.left;
    in_open_front  <= j.front;
    in_open_right  <= j.right;
    do @(posedge clk); while (!in_ready);
    pend_gap = burst ? 0 : $urandom_range(0, 3);
    if (pend_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic visit_at(int h, int x, int y, logic [2:0] opens);
    junction_t j;
    j.heading = HEAD_W'(h);
    j.x       = POS_W'(x);
    j.y       = POS_W'(y);
    {j.left, j.front, j.right} = opens;
    offer(j);
  endtask

  task automatic settle();
    if (pend_gap == 0) in_valid <= 1'b0;
    do @(posedge clk); while (decisions_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    settle();
    cfg_index <= idx;
    cfg_data  <= {(CFG_DATA_W-1)'($urandom), val};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic junction_t noise_item();
    junction_t j;
    j.heading = HEAD_W'($urandom);
    j.x       = POS_W'($urandom);
    j.y       = POS_W'($urandom);
    {j.left, j.front, j.right} = 3'($urandom);
    return j;
  endfunction

  function automatic logic signed [HEAD_W-1:0] pick_heading();
    int q;
    int h;
    q = $urandom_range(0, 4);
    h = (q - 2) * 90 + int'($urandom_range(0, 88)) - 44;
    if ($urandom_range(0, 7) == 0) begin
      if (h + 360 <= 255) h += 360;
      else if (h - 360 >= -256) h -= 360;
    end
    return HEAD_W'(h);
  endfunction

  // sites sit on a 600 mm grid, well apart from each other's match radius
  function automatic junction_t site_visit(int s, int spread);
    junction_t j;
    int cx;
    int cy;
    int dx;
    int dy;
    cx = (s % 6) * 600 - 1500;
    cy = (s / 6) * 600 - 900;
    dx = 0;
    dy = 0;
    if (site_seen[s]) begin
      dx = int'($urandom_range(0, 2 * spread)) - spread;
      dy = int'($urandom_range(0, 2 * spread)) - spread;
    end
    site_seen[s] = 1'b1;
    j.heading = pick_heading();
    j.x       = POS_W'(cx + dx);
    j.y       = POS_W'(cy + dy);
    {j.left, j.front, j.right} = 3'($urandom);
    return j;
  endfunction

  task automatic test_reset_tremaux();
    visit_at(0, 4000, 2000, 3'b111);       // first decision of the run
    visit_at(180, 4259, 2000, 3'b110);     // just inside the match radius
    visit_at(90, 4000, 2260, 3'b011);      // exactly on the radius: new junction
    visit_at(-90, 4000, 2000, 3'b000);     // dead end
    visit_at(0, 6000, -3000, 3'b101);
    visit_at(0, 6300, -3000, 3'b101);
    visit_at(180, 6150, -3000, 3'b111);    // equidistant, earlier junction wins
    visit_at(-180, -6375, 3025, 3'b010);   // halves round away from zero
    visit_at(45, 6375, -3025, 3'b001);     // lies near the junction at 6300, -3000, so it snaps there
    visit_at(-256, 8191, 8191, 3'b111);    // heading needs wrapping
    visit_at(255, -8192, -8192, 3'b111);
    visit_at(-180, 6350, 6350, 3'b111);    // lands on a clamped junction
    visit_at(44, 4000, 2000, 3'b111);
    visit_at(-45, 4010, 1990, 3'b111);
    visit_at(-46, 4000, 2000, 3'b111);
    visit_at(135, 3990, 2010, 3'b111);
    visit_at(-135, 4000, 2000, 3'b100);
  endtask

  task automatic test_wall_follow_directed();
    write_reg(CFG_UNUSED_LO, 1'b1);
    write_reg(CFG_UNUSED_HI, 1'b0);
    write_reg(CFG_STRATEGY_MODE, WALL_FOLLOW);
    write_reg(CFG_HAND_RULE, LEFT_HAND);
    visit_at(0, 4000, 2000, 3'b100);
    visit_at(90, -8192, 8191, 3'b010);
    visit_at(-90, 0, 0, 3'b001);
    visit_at(180, 4000, 2000, 3'b000);
    write_reg(CFG_HAND_RULE, RIGHT_HAND);
    visit_at(0, 4000, 2000, 3'b111);
    visit_at(-180, 8191, -8192, 3'b110);
    visit_at(90, 100, -100, 3'b100);
    visit_at(-90, 4000, 2000, 3'b000);
  endtask

  // well-formed traversals of the site grid, with a few near misses and stray beats
  task automatic test_maze_walk(logic hand, int n);
    int k;
    int r;
    write_reg(CFG_STRATEGY_MODE, TREMAUX);
    write_reg(CFG_HAND_RULE, hand);
    for (k = 0; k < n; k++) begin
      burst = (k % 100) >= 85;
      r = $urandom_range(0, 99);
      if (r < 96) offer(site_visit($urandom_range(0, NSITES - 1), 150));
      else if (r < 98) offer(site_visit($urandom_range(0, NSITES - 1), 320));
      else offer(noise_item());
    end
    burst = 1'b0;
  endtask

  task automatic test_wall_follow_random(int n);
    int k;
    write_reg(CFG_STRATEGY_MODE, WALL_FOLLOW);
    write_reg(CFG_HAND_RULE, LEFT_HAND);
    for (k = 0; k < n; k++) begin
      if (k == n / 2) write_reg(CFG_HAND_RULE, RIGHT_HAND);
      offer(noise_item());
    end
  endtask

  // result side stalls for a long stretch while beats keep coming, so in_ready drops
  task automatic test_backpressure();
    int k;
    write_reg(CFG_STRATEGY_MODE, TREMAUX);
    hold_cycles = 400;
    burst = 1'b1;
    for (k = 0; k < 16; k++) offer(site_visit($urandom_range(0, NSITES - 1), 150));
    burst = 1'b0;
  endtask

  // stray positions fill the table; after that unmatched decisions fall back to the hand rule
  task automatic test_table_overflow(int n);
    int k;
    write_reg(CFG_STRATEGY_MODE, TREMAUX);
    write_reg(CFG_HAND_RULE, LEFT_HAND);
    for (k = 0; k < n; k++) begin
      if (k == n / 2) write_reg(CFG_HAND_RULE, RIGHT_HAND);
      if ($urandom_range(0, 9) < 6) offer(noise_item());
      else offer(site_visit($urandom_range(0, NSITES - 1), 150));
    end
  endtask

  initial begin
    foreach (site_seen[s]) site_seen[s] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_tremaux();
    test_wall_follow_directed();
    test_maze_walk(LEFT_HAND, 300);
    test_wall_follow_random(200);
    test_backpressure();
    test_maze_walk(RIGHT_HAND, 290);
    test_table_overflow(250);
    test_maze_walk(1'($urandom), 270);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run: %0d decisions, %0d result beats; %0d snapped, %0d junctions stored",
             n_items, n_beats, n_snapped, n_new);
    $display("run: %0d table-full fallbacks, %0d wall-follow decisions, %0d mismatches",
             n_full, n_wall, mismatches);
    if (mismatches == 0 && decisions_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("timeout with %0d results outstanding", decisions_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
